[src/tlam_pkg.sv]
// Shared types, constants and helper functions for the two-line assembly
// scheduling block. Used by every module under src; depends on nothing.
package tlam_pkg;

    // Station cost width; costs and transfers are taken in these bits
    localparam int COST_WIDTH      = 16;
    localparam int TOTAL_WIDTH     = 32;
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    // Widest sum: leave time plus transfer plus cost
    localparam int SUM_WIDTH       = TOTAL_WIDTH + 2;

    // Queue between the front and back ends
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ENTRY_LINE0 = 2'd0,
        CFG_ENTRY_LINE1 = 2'd1,
        CFG_EXIT_LINE0  = 2'd2,
        CFG_EXIT_LINE1  = 2'd3
    } cfg_idx_t;

    // Station class assigned by the front end
    typedef enum logic [1:0] {
        KIND_MID    = 2'd0,
        KIND_FIRST  = 2'd1,
        KIND_LAST   = 2'd2,
        KIND_SINGLE = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [COST_WIDTH-1:0] cost0;
        logic [COST_WIDTH-1:0] cost1;
        logic [COST_WIDTH-1:0] xfer0;
        logic [COST_WIDTH-1:0] xfer1;
    } station_t;

    typedef struct packed {
        logic                       write;
        logic [CFG_INDEX_WIDTH-1:0] index;
        logic [CFG_WIDTH-1:0]       data;
    } cfg_write_t;

    // Clamp an exact sum to the total range
    function automatic logic [TOTAL_WIDTH-1:0] sat_value(input logic [SUM_WIDTH-1:0] sum);
        logic [TOTAL_WIDTH-1:0] res;
        if (|sum[SUM_WIDTH-1:TOTAL_WIDTH])
            res = '1;
        else
            res = sum[TOTAL_WIDTH-1:0];
        return res;
    endfunction

    // Flag a sum that does not fit the total range
    function automatic logic sat_flag(input logic [SUM_WIDTH-1:0] sum);
        return |sum[SUM_WIDTH-1:TOTAL_WIDTH];
    endfunction

    function automatic logic [TOTAL_WIDTH-1:0] least_of(input logic [TOTAL_WIDTH-1:0] p,
                                                        input logic [TOTAL_WIDTH-1:0] q);
        return (p < q) ? p : q;
    endfunction

endpackage

[src/tlam_front.sv]
// Front end: input register stage that takes station requests and classifies them.
// Depends on tlam_pkg; feeds tlam_queue.
module tlam_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tlam_pkg::COST_WIDTH-1:0] cost_line0,
    input  logic [tlam_pkg::COST_WIDTH-1:0] cost_line1,
    input  logic [tlam_pkg::COST_WIDTH-1:0] transfer_from_line0,
    input  logic [tlam_pkg::COST_WIDTH-1:0] transfer_from_line1,
    input  logic                            first_station,
    input  logic                            last_station,
    output logic                            push,
    output tlam_pkg::station_t              push_item,
    input  logic                            queue_ready
);
    import tlam_pkg::*;

    logic     front_valid_reg;
    logic     front_valid_next;
    station_t front_item_reg;
    station_t front_item_next;
    logic     load;
    kind_t    kind;

    // Classify the station by its run markers
    always_comb
    begin
        unique case ({first_station, last_station})
            2'b00: kind = KIND_MID;
            2'b10: kind = KIND_FIRST;
            2'b01: kind = KIND_LAST;
            2'b11: kind = KIND_SINGLE;
            default: kind = KIND_MID;
        endcase
    end

    // Hand over to the queue; refill in the same cycle
    assign push     = front_valid_reg && queue_ready;
    assign in_ready = !front_valid_reg || queue_ready;
    assign load     = in_valid && in_ready;
    assign push_item = front_item_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        front_item_next  = front_item_reg;
        if (load)
        begin
            front_valid_next      = 1'b1;
            front_item_next.kind  = kind;
            front_item_next.cost0 = cost_line0;
            front_item_next.cost1 = cost_line1;
            front_item_next.xfer0 = transfer_from_line0;
            front_item_next.xfer1 = transfer_from_line1;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        front_item_reg <= front_item_next;
    end

endmodule

[src/tlam_queue.sv]
// Short register queue that decouples the front end from the back end.
// Depends on tlam_pkg for the station type and depth.
module tlam_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tlam_pkg::station_t push_item,
    output logic               queue_ready,
    input  logic               pop,
    output logic               queue_valid,
    output tlam_pkg::station_t queue_item
);
    import tlam_pkg::*;

    station_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg;
    logic [QPTR_WIDTH-1:0] wr_ptr_next;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg;
    logic [QPTR_WIDTH-1:0] rd_ptr_next;
    logic [QCNT_WIDTH-1:0] count_reg;
    logic [QCNT_WIDTH-1:0] count_next;

    assign queue_valid = (count_reg != '0);
    assign queue_ready = (count_reg != QCNT_WIDTH'(QUEUE_DEPTH));
    assign queue_item  = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + QCNT_WIDTH'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_WIDTH'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the incoming station
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_WIDTH'(QUEUE_DEPTH))
        else $error("queue fill level beyond depth");
`endif

endmodule

[src/tlam_back.sv]
// Back end: per-line recurrence, finish stage with exit times, output register.
// Depends on tlam_pkg; takes stations from tlam_queue and holds the config registers.
module tlam_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tlam_pkg::cfg_write_t             cfg,
    input  logic                             queue_valid,
    input  tlam_pkg::station_t               queue_item,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tlam_pkg::TOTAL_WIDTH-1:0] best_total,
    output logic                             saturated
);
    import tlam_pkg::*;

    // Configuration registers
    logic [CFG_WIDTH-1:0] entry0_reg;
    logic [CFG_WIDTH-1:0] entry1_reg;
    logic [CFG_WIDTH-1:0] exit0_reg;
    logic [CFG_WIDTH-1:0] exit1_reg;

    // Recurrence state
    logic [TOTAL_WIDTH-1:0] leave0_reg;
    logic [TOTAL_WIDTH-1:0] leave0_next;
    logic [TOTAL_WIDTH-1:0] leave1_reg;
    logic [TOTAL_WIDTH-1:0] leave1_next;
    logic                   ovf_reg;
    logic                   ovf_next;

    // Finish stage
    logic                   fin_valid_reg;
    logic                   fin_valid_next;
    logic                   fin_fresh_reg;
    logic [TOTAL_WIDTH-1:0] fin_leave0_reg;
    logic [TOTAL_WIDTH-1:0] fin_leave1_reg;
    logic                   fin_ovf_reg;

    // Output register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [TOTAL_WIDTH-1:0] out_total_reg;
    logic                   out_sat_reg;

    logic                 is_first;
    logic                 is_last;
    logic                 fin_ready;
    logic                 fin_load;
    logic                 out_load;
    logic                 eff_ovf;
    logic                 item_ovf;
    logic [SUM_WIDTH-1:0] c0;
    logic [SUM_WIDTH-1:0] c1;
    logic [SUM_WIDTH-1:0] t0;
    logic [SUM_WIDTH-1:0] t1;
    logic [SUM_WIDTH-1:0] p0;
    logic [SUM_WIDTH-1:0] p1;
    logic [SUM_WIDTH-1:0] start0;
    logic [SUM_WIDTH-1:0] start1;
    logic [SUM_WIDTH-1:0] stay0;
    logic [SUM_WIDTH-1:0] move0;
    logic [SUM_WIDTH-1:0] stay1;
    logic [SUM_WIDTH-1:0] move1;
    logic [SUM_WIDTH-1:0] done0;
    logic [SUM_WIDTH-1:0] done1;
    logic                 exit_ovf;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry0_reg <= '0;
            entry1_reg <= '0;
            exit0_reg  <= '0;
            exit1_reg  <= '0;
        end
        else if (cfg.write)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_ENTRY_LINE0: entry0_reg <= cfg.data;
                CFG_ENTRY_LINE1: entry1_reg <= cfg.data;
                CFG_EXIT_LINE0:  exit0_reg  <= cfg.data;
                CFG_EXIT_LINE1:  exit1_reg  <= cfg.data;
            endcase
        end
    end

    // Decode the station class
    always_comb
    begin
        unique case (queue_item.kind)
            KIND_MID:    begin is_first = 1'b0; is_last = 1'b0; end
            KIND_FIRST:  begin is_first = 1'b1; is_last = 1'b0; end
            KIND_LAST:   begin is_first = 1'b0; is_last = 1'b1; end
            KIND_SINGLE: begin is_first = 1'b1; is_last = 1'b1; end
        endcase
    end

    // Handshake between stages
    assign out_load  = fin_valid_reg && (!out_valid_reg || out_ready);
    assign fin_ready = !fin_valid_reg || out_load;
    assign pop       = queue_valid && (!is_last || fin_ready);
    assign fin_load  = pop && is_last;

    // Exit sums of the run waiting in the finish stage
    assign done0    = SUM_WIDTH'(fin_leave0_reg) + SUM_WIDTH'(exit0_reg);
    assign done1    = SUM_WIDTH'(fin_leave1_reg) + SUM_WIDTH'(exit1_reg);
    assign exit_ovf = sat_flag(done0) || sat_flag(done1);

    // Fold exit overflow into the run flag once, right after the finish stage loads
    assign eff_ovf = ovf_reg || (fin_valid_reg && fin_fresh_reg && exit_ovf);

    // Per-line recurrence
    assign c0 = SUM_WIDTH'(queue_item.cost0);
    assign c1 = SUM_WIDTH'(queue_item.cost1);
    assign t0 = SUM_WIDTH'(queue_item.xfer0);
    assign t1 = SUM_WIDTH'(queue_item.xfer1);
    assign p0 = SUM_WIDTH'(leave0_reg);
    assign p1 = SUM_WIDTH'(leave1_reg);

    assign start0 = SUM_WIDTH'(entry0_reg) + c0;
    assign start1 = SUM_WIDTH'(entry1_reg) + c1;
    assign stay0  = p0 + c0;
    assign move0  = p1 + t1 + c0;
    assign stay1  = p1 + c1;
    assign move1  = p0 + t0 + c1;

    always_comb
    begin
        if (is_first)
        begin
            leave0_next = sat_value(start0);
            leave1_next = sat_value(start1);
            item_ovf    = sat_flag(start0) || sat_flag(start1);
            ovf_next    = item_ovf;
        end
        else
        begin
            leave0_next = least_of(sat_value(stay0), sat_value(move0));
            leave1_next = least_of(sat_value(stay1), sat_value(move1));
            item_ovf    = sat_flag(stay0) || sat_flag(move0)
                       || sat_flag(stay1) || sat_flag(move1);
            ovf_next    = eff_ovf || item_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leave0_reg <= '0;
            leave1_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (pop)
        begin
            leave0_reg <= leave0_next;
            leave1_reg <= leave1_next;
            ovf_reg    <= ovf_next;
        end
        else
        begin
            ovf_reg <= eff_ovf;
        end
    end

    // Finish stage: hold the leave times of a completed run
    always_comb
    begin
        if (fin_load)
            fin_valid_next = 1'b1;
        else if (out_load)
            fin_valid_next = 1'b0;
        else
            fin_valid_next = fin_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            fin_fresh_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            fin_fresh_reg <= fin_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            fin_leave0_reg <= leave0_next;
            fin_leave1_reg <= leave1_next;
            fin_ovf_reg    <= ovf_next;
        end
    end

    // Output register: pick the smaller total
    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_total_reg <= least_of(sat_value(done0), sat_value(done1));
            out_sat_reg   <= fin_ovf_reg || exit_ovf;
        end
    end

    assign out_valid  = out_valid_reg;
    assign best_total = out_total_reg;
    assign saturated  = out_sat_reg;

`ifndef SYNTHESIS
    a_last_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        fin_load |-> fin_ready)
        else $error("last station taken while finish stage is blocked");

    a_fresh_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fin_fresh_reg |-> fin_valid_reg)
        else $error("fresh flag set without a run in the finish stage");

    a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("finished run did not reach the output register");
`endif

endmodule

[src/two_line_assembly_min_time.sv]
// Top level of the two-line assembly scheduling block.
// Depends on tlam_pkg, tlam_front, tlam_queue and tlam_back.

// One station request per clock cycle is taken at a sustained rate while the
// output is not stalled; the limit is the back end's recurrence step (a
// two-term and a three-term add, clamps and a minimum per line), which closes
// on the two leave-time registers each cycle. A request passes an input
// register, a two-entry queue, the recurrence step, a finish stage that adds
// the exit times, and an output register. Stations that are not last produce
// no result. Configuration writes take effect at the next clock edge and are
// expected only while no station is in flight.
module two_line_assembly_min_time (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [tlam_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tlam_pkg::CFG_WIDTH-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [tlam_pkg::COST_WIDTH-1:0]      cost_line0,
    input  logic [tlam_pkg::COST_WIDTH-1:0]      cost_line1,
    input  logic [tlam_pkg::COST_WIDTH-1:0]      transfer_from_line0,
    input  logic [tlam_pkg::COST_WIDTH-1:0]      transfer_from_line1,
    input  logic                                 first_station,
    input  logic                                 last_station,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [tlam_pkg::TOTAL_WIDTH-1:0]     best_total,
    output logic                                 saturated
);
    import tlam_pkg::*;

    cfg_write_t cfg;
    logic       push;
    station_t   push_item;
    logic       queue_ready;
    logic       pop;
    logic       queue_valid;
    station_t   queue_item;

    // Bundle the configuration write
    assign cfg.write = cfg_write;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    tlam_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .cost_line0          (cost_line0),
        .cost_line1          (cost_line1),
        .transfer_from_line0 (transfer_from_line0),
        .transfer_from_line1 (transfer_from_line1),
        .first_station       (first_station),
        .last_station        (last_station),
        .push                (push),
        .push_item           (push_item),
        .queue_ready         (queue_ready)
    );

    tlam_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_item   (push_item),
        .queue_ready (queue_ready),
        .pop         (pop),
        .queue_valid (queue_valid),
        .queue_item  (queue_item)
    );

    tlam_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .queue_valid (queue_valid),
        .queue_item  (queue_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .best_total  (best_total),
        .saturated   (saturated)
    );

endmodule

[verif/tb.sv]
// Testbench for two_line_assembly_min_time: drives station requests and
// register writes, predicts each best total and checks it on the result port.
// Depends on tlam_pkg and the block under src.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlam_pkg::*;

    localparam int SUM_BITS    = TOTAL_WIDTH + 2;
    localparam int SETTLE      = 12;
    localparam int CYCLE_LIMIT = 600000;
    localparam int REPORT_CAP  = 100;

    typedef struct packed {
        logic [COST_WIDTH-1:0] cost0;
        logic [COST_WIDTH-1:0] cost1;
        logic [COST_WIDTH-1:0] xfer0;
        logic [COST_WIDTH-1:0] xfer1;
        logic                  first;
        logic                  last;
    } station_req_t;

    typedef struct packed {
        logic [TOTAL_WIDTH-1:0] total;
        logic                   sat;
    } finish_t;

    // Track the best leave time per line and queue the totals still owed
    class min_time_board;
        logic [CFG_WIDTH-1:0]   entry0 = '0;
        logic [CFG_WIDTH-1:0]   entry1 = '0;
        logic [CFG_WIDTH-1:0]   exit0  = '0;
        logic [CFG_WIDTH-1:0]   exit1  = '0;
        logic [TOTAL_WIDTH-1:0] leave0 = '0;
        logic [TOTAL_WIDTH-1:0] leave1 = '0;
        bit                     overflow_run;
        finish_t                totals_due[$];
        int                     errors;

        function void note_config(cfg_idx_t idx, logic [CFG_WIDTH-1:0] value);
            case (idx)
                CFG_ENTRY_LINE0: entry0 = value;
                CFG_ENTRY_LINE1: entry1 = value;
                CFG_EXIT_LINE0:  exit0  = value;
                CFG_EXIT_LINE1:  exit1  = value;
                default: ;
            endcase
        endfunction

        // Clamp to the total range; any clamp marks the run
        function logic [TOTAL_WIDTH-1:0] clamp_total(logic [SUM_BITS-1:0] sum);
            if (sum[SUM_BITS-1:TOTAL_WIDTH] != '0)
            begin
                overflow_run = 1'b1;
                return '1;
            end
            return sum[TOTAL_WIDTH-1:0];
        endfunction

        function logic [TOTAL_WIDTH-1:0] smaller(logic [TOTAL_WIDTH-1:0] p,
                                                 logic [TOTAL_WIDTH-1:0] q);
            return (p < q) ? p : q;
        endfunction

        function void note_station(station_req_t s);
            logic [SUM_BITS-1:0]    sum;
            logic [TOTAL_WIDTH-1:0] stay0, move0, stay1, move1, done0, done1;
            finish_t                owed;
            if (s.first)
            begin
                // Start a run: transfers ignored, flag starts clear
                overflow_run = 1'b0;
                sum = entry0 + s.cost0;
                leave0 = clamp_total(sum);
                sum = entry1 + s.cost1;
                leave1 = clamp_total(sum);
            end
            else
            begin
                sum = leave0 + s.cost0;
                stay0 = clamp_total(sum);
                sum = leave1 + s.xfer1 + s.cost0;
                move0 = clamp_total(sum);
                sum = leave1 + s.cost1;
                stay1 = clamp_total(sum);
                sum = leave0 + s.xfer0 + s.cost1;
                move1 = clamp_total(sum);
                leave0 = smaller(stay0, move0);
                leave1 = smaller(stay1, move1);
            end
            if (s.last)
            begin
                // Exit sums may clamp too, so read the flag after them
                sum = leave0 + exit0;
                done0 = clamp_total(sum);
                sum = leave1 + exit1;
                done1 = clamp_total(sum);
                owed.total = smaller(done0, done1);
                owed.sat   = overflow_run;
                totals_due.push_back(owed);
            end
        endfunction

        function void check_total(logic [TOTAL_WIDTH-1:0] total, logic sat);
            finish_t want;
            if (totals_due.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: unexpected result best_total %0h saturated %0b",
                             $time, total, sat);
                return;
            end
            want = totals_due.pop_front();
            if (total !== want.total)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: best_total expected %0h actual %0h",
                             $time, want.total, total);
            end
            if (sat !== want.sat)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, want.sat, sat);
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]       cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [COST_WIDTH-1:0]      cost_line0;
    logic [COST_WIDTH-1:0]      cost_line1;
    logic [COST_WIDTH-1:0]      transfer_from_line0;
    logic [COST_WIDTH-1:0]      transfer_from_line1;
    logic                       first_station;
    logic                       last_station;
    logic                       out_valid;
    logic                       out_ready;
    logic [TOTAL_WIDTH-1:0]     best_total;
    logic                       saturated;

    min_time_board board;
    int            stations_sent;
    int            cycle_count;
    bit            in_burst;
    bit            out_burst;

    two_line_assembly_min_time dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .cost_line0          (cost_line0),
        .cost_line1          (cost_line1),
        .transfer_from_line0 (transfer_from_line0),
        .transfer_from_line1 (transfer_from_line1),
        .first_station       (first_station),
        .last_station        (last_station),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .best_total          (best_total),
        .saturated           (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL two_line_assembly_min_time");
            $finish;
        end
    end

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            board.check_total(best_total, saturated);
    end

    // Stall the result side for a random number of cycles per result
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = out_burst ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 31) == 0)
                out_burst = !out_burst;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    function automatic logic [COST_WIDTH-1:0] rand_cost();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic station_req_t mk(logic [COST_WIDTH-1:0] c0, logic [COST_WIDTH-1:0] c1,
                                        logic [COST_WIDTH-1:0] t0, logic [COST_WIDTH-1:0] t1,
                                        logic f, logic l);
        station_req_t s;
        s.cost0 = c0;
        s.cost1 = c1;
        s.xfer0 = t0;
        s.xfer1 = t1;
        s.first = f;
        s.last  = l;
        return s;
    endfunction

    function automatic station_req_t rand_station(logic f, logic l);
        return mk(rand_cost(), rand_cost(), rand_cost(), rand_cost(), f, l);
    endfunction

    // Offer one station request and hold it until accepted
    task automatic push_station(station_req_t s);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 31) == 0)
            in_burst = !in_burst;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid            <= 1'b1;
        cost_line0          <= s.cost0;
        cost_line1          <= s.cost1;
        transfer_from_line0 <= s.xfer0;
        transfer_from_line1 <= s.xfer1;
        first_station       <= s.first;
        last_station        <= s.last;
        do @(posedge clk); while (in_ready !== 1'b1);
        board.note_station(s);
        stations_sent++;
    endtask

    // Drop the request line, drain owed totals, let mid stations finish
    task automatic settle();
        in_valid <= 1'b0;
        while (board.totals_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic put_reg(cfg_idx_t idx, logic [CFG_WIDTH-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        board.note_config(idx, value);
    endtask

    task automatic load_settings(logic [CFG_WIDTH-1:0] e0, logic [CFG_WIDTH-1:0] e1,
                                 logic [CFG_WIDTH-1:0] x0, logic [CFG_WIDTH-1:0] x1);
        put_reg(CFG_ENTRY_LINE0, e0);
        put_reg(CFG_ENTRY_LINE1, e1);
        put_reg(CFG_EXIT_LINE0, x0);
        put_reg(CFG_EXIT_LINE1, x1);
        cfg_write <= 1'b0;
    endtask

    // Mostly well-formed runs, with stray stations and runs left open
    task automatic random_stations(int n);
        int target;
        int shape;
        target = stations_sent + n;
        while (stations_sent < target)
        begin
            shape = $urandom_range(0, 99);
            if (shape < 65)
            begin
                push_station(rand_station(1'b1, 1'b0));
                repeat ($urandom_range(0, 10)) push_station(rand_station(1'b0, 1'b0));
                push_station(rand_station(1'b0, 1'b1));
            end
            else if (shape < 78)
                push_station(rand_station(1'b1, 1'b1));
            else if (shape < 90)
                repeat ($urandom_range(1, 4))
                    push_station(rand_station($urandom_range(0, 1), $urandom_range(0, 1)));
            else
            begin
                push_station(rand_station(1'b1, 1'b0));
                repeat ($urandom_range(0, 5)) push_station(rand_station(1'b0, 1'b0));
            end
        end
    endtask

    task automatic random_phase(logic [CFG_WIDTH-1:0] e0, logic [CFG_WIDTH-1:0] e1,
                                logic [CFG_WIDTH-1:0] x0, logic [CFG_WIDTH-1:0] x1);
        settle();
        load_settings(e0, e1, x0, x1);
        random_stations(255);
    endtask

    initial
    begin
        board = new();
        rst_n               <= 1'b0;
        cfg_write           <= 1'b0;
        cfg_index           <= CFG_ENTRY_LINE0;
        cfg_data            <= '0;
        in_valid            <= 1'b0;
        cost_line0          <= '0;
        cost_line1          <= '0;
        transfer_from_line0 <= '0;
        transfer_from_line1 <= '0;
        first_station       <= 1'b0;
        last_station        <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stations before any first mark continue from the reset state
        push_station(mk(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 1'b0));
        push_station(mk(16'h0001, 16'h0002, 16'h0003, 16'h0004, 1'b0, 1'b1));

        settle();
        load_settings(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000);
        // One-station runs at the extremes
        push_station(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
        push_station(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1));
        // First station ignores transfers; then stay and move paths
        push_station(mk(16'd10, 16'd2000, 16'd5, 16'd7, 1'b1, 1'b0));
        push_station(mk(16'd300, 16'd1, 16'h0000, 16'h0000, 1'b0, 1'b0));
        push_station(mk(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
        push_station(mk(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 1'b1));
        // Continue past a last station without a new first
        push_station(mk(16'd5, 16'd5, 16'd1, 16'd1, 1'b0, 1'b1));
        // Restart twice in a row
        push_station(mk(16'd100, 16'd200, 16'h0000, 16'h0000, 1'b1, 1'b0));
        push_station(mk(16'd7, 16'd9, 16'h0000, 16'h0000, 1'b1, 1'b0));
        push_station(mk(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 1'b1));
        push_station(mk(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b1, 1'b0));
        push_station(mk(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b0, 1'b0));
        push_station(mk(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b0, 1'b1));

        random_phase(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        random_phase($urandom, $urandom, $urandom, $urandom);
        random_phase(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        random_phase($urandom, $urandom, $urandom, $urandom);

        settle();
        if (board.errors == 0 && board.totals_due.size() == 0)
            $display("PASS two_line_assembly_min_time");
        else
            $display("FAIL two_line_assembly_min_time");
        $finish;
    end

endmodule

[files.f]
src/tlam_pkg.sv
src/tlam_front.sv
src/tlam_queue.sv
src/tlam_back.sv
src/two_line_assembly_min_time.sv
verif/tb.sv
